// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PIS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pis checker: property failed");

// checked at every edge, reset included
`define PIS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pis checker: property failed");

`endif

// ===== sv/pis_pkg.sv =====
package pis_pkg;

    localparam int NUM_BINS     = 1500;
    localparam int BIN_WIDTH_US = 10;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int ONE_SEC_US   = 1000000;
    localparam int OUTLIER_SECS = 5;
    localparam int OUTLIER_US   = OUTLIER_SECS * ONE_SEC_US;
    localparam int NUM_CLASSES  = 256;

    localparam int STAMP_W     = 48;
    localparam int CNT_W       = 32;
    localparam int ACC_W       = 64;
    localparam int READ_IDX_W  = 11;
    localparam int CLS_IDX_W   = $clog2(NUM_CLASSES);
    localparam int BIN_IDX_W   = $clog2(NUM_BINS + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // gaps that reach the bin divider are below the outlier limit
    localparam int GAP_W        = $clog2(OUTLIER_US);
    localparam int RECIP_SHIFT  = GAP_W + $clog2(BIN_WIDTH_US);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(BIN_WIDTH_US) - 64'd1) / 64'(BIN_WIDTH_US);
    localparam int RECIP_W      = GAP_W + 2;
    localparam int PROD_W       = GAP_W + RECIP_W;
    localparam int QUOT_W       = PROD_W - RECIP_SHIFT;

    localparam int CLR_LEN = (NUM_BINS + 1 > NUM_CLASSES) ? NUM_BINS + 1 : NUM_CLASSES;
    localparam int CLR_W   = $clog2(CLR_LEN);

    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STATS_MODE  = 3'd0,
        REG_FILTER_MODE = 3'd1,
        REG_SOURCE_ADDR = 3'd2,
        REG_SOURCE_PORT = 3'd3,
        REG_DEST_PORT   = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RD_CLASS,
        OP_RD_BIN,
        OP_UPD_CLASS,
        OP_UPD_BIN
    } t_op;

    typedef struct packed {
        logic                  func;
        logic [15:0]           ethertype;
        logic [7:0]            ip_protocol;
        logic [31:0]           src_addr;
        logic [15:0]           src_port;
        logic [15:0]           dst_port;
        logic [7:0]            tos_class;
        logic [STAMP_W-1:0]    arrival_us;
        logic [READ_IDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic             matched;
        logic             updated;
        logic [CNT_W-1:0] entry_count;
        logic [ACC_W-1:0] entry_sum_us;
        logic [ACC_W-1:0] entry_sum_sq;
        logic [CNT_W-1:0] total_matched;
        logic [CNT_W-1:0] unmatched_total;
    } t_out_item;

    typedef struct packed {
        t_op                   op;
        logic                  matched;
        logic                  outlier;
        logic [READ_IDX_W-1:0] index;
        logic [GAP_W-1:0]      gap;
        logic [CNT_W-1:0]      total_matched;
        logic [CNT_W-1:0]      unmatched_total;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ACC_W-1:0] sum;
        logic [ACC_W-1:0] sum_sq;
    } t_cls_entry;

endpackage

// ===== sv/pis_front.sv =====
module pis_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  pis_pkg::t_in_item              i_in_item,
    output logic                           o_full,
    input  logic                           i_busy,
    input  logic                           i_q_full,
    output logic                           o_cmd_push,
    output pis_pkg::t_cmd                  o_cmd,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic        r_stats_mode;
    logic        r_filter_mode;
    logic [31:0] r_source_addr;
    logic [15:0] r_source_port;
    logic [15:0] r_dest_port;

    logic [pis_pkg::STAMP_W-1:0] r_last_stamp, n_last_stamp;
    logic                        r_stamp_valid, n_stamp_valid;
    logic [pis_pkg::CNT_W-1:0]   r_matched_total, n_matched_total;
    logic [pis_pkg::CNT_W-1:0]   r_reject_total, n_reject_total;

    logic                        accept;
    logic                        ip_udp;
    logic                        wild_ok;
    logic                        pass;
    logic                        miss;
    logic [pis_pkg::STAMP_W-1:0] gap_full;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_q_full || i_busy;
    assign accept      = i_push && !o_full;
    assign o_cmd_push  = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats_mode  <= 1'b0;
            r_filter_mode <= 1'b0;
            r_source_addr <= '0;
            r_source_port <= '0;
            r_dest_port   <= '0;
        end else if (i_cfg_valid) begin
            unique case (pis_pkg::t_reg_idx'(i_cfg_index))
                pis_pkg::REG_STATS_MODE:  r_stats_mode  <= i_cfg_data[0];
                pis_pkg::REG_FILTER_MODE: r_filter_mode <= i_cfg_data[0];
                pis_pkg::REG_SOURCE_ADDR: r_source_addr <= i_cfg_data[31:0];
                pis_pkg::REG_SOURCE_PORT: r_source_port <= i_cfg_data[15:0];
                pis_pkg::REG_DEST_PORT:   r_dest_port   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // filter
    always_comb begin
        ip_udp  = (i_in_item.ethertype == pis_pkg::ETH_IPV4)
               && (i_in_item.ip_protocol == pis_pkg::PROTO_UDP);
        wild_ok = ((r_source_addr == '0) || (i_in_item.src_addr == r_source_addr))
               && ((r_source_port == '0) || (i_in_item.src_port == r_source_port))
               && ((r_dest_port == '0) || (i_in_item.dst_port == r_dest_port));
        if (!r_filter_mode) begin
            pass = ip_udp && (i_in_item.src_addr == r_source_addr);
            miss = 1'b0;
        end else begin
            pass = ip_udp && wild_ok;
            miss = ip_udp && !wild_ok;
        end
    end

    assign gap_full = i_in_item.arrival_us - r_last_stamp;

    always_comb begin
        n_last_stamp    = r_last_stamp;
        n_stamp_valid   = r_stamp_valid;
        n_matched_total = r_matched_total;
        n_reject_total  = r_reject_total;
        o_cmd.op        = pis_pkg::OP_NONE;
        o_cmd.matched   = 1'b0;
        o_cmd.outlier   = 1'b0;
        o_cmd.index     = i_in_item.func ? i_in_item.read_index
                                         : pis_pkg::READ_IDX_W'(i_in_item.tos_class);
        o_cmd.gap       = gap_full[pis_pkg::GAP_W-1:0];
        if (i_in_item.func) begin
            if (!r_stats_mode) begin
                if (32'(i_in_item.read_index) < 32'(pis_pkg::NUM_CLASSES)) begin
                    o_cmd.op = pis_pkg::OP_RD_CLASS;
                end
            end else if (32'(i_in_item.read_index) <= 32'(pis_pkg::NUM_BINS)) begin
                o_cmd.op = pis_pkg::OP_RD_BIN;
            end
        end else if (pass) begin
            o_cmd.matched = 1'b1;
            if (r_stamp_valid) begin
                if (!r_stats_mode) begin
                    if (gap_full < pis_pkg::STAMP_W'(pis_pkg::ONE_SEC_US)) begin
                        o_cmd.op = pis_pkg::OP_UPD_CLASS;
                    end
                end else begin
                    o_cmd.op      = pis_pkg::OP_UPD_BIN;
                    o_cmd.outlier = gap_full >= pis_pkg::STAMP_W'(pis_pkg::OUTLIER_US);
                end
            end
            if (r_stats_mode) begin
                n_matched_total = r_matched_total + 1'b1;
            end
            n_last_stamp  = i_in_item.arrival_us;
            n_stamp_valid = 1'b1;
        end else if (miss) begin
            n_reject_total = r_reject_total + 1'b1;
        end
        o_cmd.total_matched   = n_matched_total;
        o_cmd.unmatched_total = n_reject_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp    <= '0;
            r_stamp_valid   <= 1'b0;
            r_matched_total <= '0;
            r_reject_total  <= '0;
        end else if (accept) begin
            r_last_stamp    <= n_last_stamp;
            r_stamp_valid   <= n_stamp_valid;
            r_matched_total <= n_matched_total;
            r_reject_total  <= n_reject_total;
        end
    end

endmodule

// ===== sv/pis_cmd_queue.sv =====
module pis_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pis_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output pis_pkg::t_cmd o_head,
    input  logic          i_pop
);

    localparam int PTR_W = (pis_pkg::CMDQ_DEPTH > 1) ? $clog2(pis_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(pis_pkg::CMDQ_DEPTH + 1);

    pis_pkg::t_cmd    r_q [pis_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == CNT_W'(pis_pkg::CMDQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(pis_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(pis_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== sv/pis_back.sv =====
module pis_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  pis_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_busy,
    output logic               o_empty,
    input  logic               i_pop,
    output pis_pkg::t_out_item o_out_item
);

    localparam int OQ_PTR_W = (pis_pkg::OUTQ_DEPTH > 1) ? $clog2(pis_pkg::OUTQ_DEPTH) : 1;
    localparam int OQ_CNT_W = $clog2(pis_pkg::OUTQ_DEPTH + 1);

    // statistics memories
    pis_pkg::t_cls_entry       cls_mem [pis_pkg::NUM_CLASSES];
    logic [pis_pkg::CNT_W-1:0] bin_mem [pis_pkg::NUM_BINS + 1];

    logic                        r_clearing;
    logic [pis_pkg::CLR_W-1:0]   r_clr_idx;

    logic                        en;
    logic [pis_pkg::RECIP_W-1:0] mul_b;
    logic [pis_pkg::PROD_W-1:0]  mul_prod;

    logic                        r_p1_valid;
    pis_pkg::t_cmd               r_p1_cmd;
    logic [pis_pkg::PROD_W-1:0]  r_p1_prod;

    logic [pis_pkg::QUOT_W-1:0]    quot;
    logic [pis_pkg::BIN_IDX_W-1:0] bin_rd_addr;
    logic [pis_pkg::CLS_IDX_W-1:0] cls_rd_addr;

    logic                          r_p2_valid;
    pis_pkg::t_cmd                 r_p2_cmd;
    logic [pis_pkg::PROD_W-1:0]    r_p2_sq;
    logic [pis_pkg::BIN_IDX_W-1:0] r_p2_bin_addr;
    logic [pis_pkg::CLS_IDX_W-1:0] r_p2_cls_addr;
    pis_pkg::t_cls_entry           r_cls_rd;
    logic [pis_pkg::CNT_W-1:0]     r_bin_rd;

    // latest write of each memory, for back-to-back updates of one entry
    logic                          r_fw_cls_valid;
    logic [pis_pkg::CLS_IDX_W-1:0] r_fw_cls_addr;
    pis_pkg::t_cls_entry           r_fw_cls_data;
    logic                          r_fw_bin_valid;
    logic [pis_pkg::BIN_IDX_W-1:0] r_fw_bin_addr;
    logic [pis_pkg::CNT_W-1:0]     r_fw_bin_data;

    pis_pkg::t_cls_entry           cur_cls, new_cls;
    logic [pis_pkg::CNT_W-1:0]     cur_bin, new_bin;

    logic                          cls_we, bin_we;
    logic [pis_pkg::CLS_IDX_W-1:0] cls_wa;
    logic [pis_pkg::BIN_IDX_W-1:0] bin_wa;
    pis_pkg::t_cls_entry           cls_wd;
    logic [pis_pkg::CNT_W-1:0]     bin_wd;
    logic                          upd_cls, upd_bin;

    pis_pkg::t_out_item            res;
    pis_pkg::t_out_item            r_oq [pis_pkg::OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0]           r_oq_wp, r_oq_rp;
    logic [OQ_CNT_W-1:0]           r_oq_cnt;
    logic                          oq_push, oq_pop;

    assign o_busy    = r_clearing;
    assign en        = !r_clearing && (r_oq_cnt != OQ_CNT_W'(pis_pkg::OUTQ_DEPTH));
    assign o_cmd_pop = en && i_cmd_valid;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == pis_pkg::CLR_W'(pis_pkg::CLR_LEN - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // shared multiplier: squared gap or reciprocal of the bin width
    assign mul_b    = (i_cmd.op == pis_pkg::OP_UPD_CLASS)
                    ? pis_pkg::RECIP_W'(i_cmd.gap)
                    : pis_pkg::RECIP_W'(pis_pkg::RECIP);
    assign mul_prod = pis_pkg::PROD_W'(i_cmd.gap) * pis_pkg::PROD_W'(mul_b);

    // bin index and read addresses
    assign quot = r_p1_prod[pis_pkg::PROD_W-1:pis_pkg::RECIP_SHIFT];
    always_comb begin
        cls_rd_addr = r_p1_cmd.index[pis_pkg::CLS_IDX_W-1:0];
        if (r_p1_cmd.op == pis_pkg::OP_RD_BIN) begin
            bin_rd_addr = pis_pkg::BIN_IDX_W'(r_p1_cmd.index);
        end else if (r_p1_cmd.outlier || (32'(quot) > 32'(pis_pkg::NUM_BINS))) begin
            bin_rd_addr = pis_pkg::BIN_IDX_W'(pis_pkg::NUM_BINS);
        end else begin
            bin_rd_addr = pis_pkg::BIN_IDX_W'(quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= i_cmd_valid;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_cmd      <= i_cmd;
            r_p1_prod     <= mul_prod;
            r_p2_cmd      <= r_p1_cmd;
            r_p2_sq       <= r_p1_prod;
            r_p2_bin_addr <= bin_rd_addr;
            r_p2_cls_addr <= cls_rd_addr;
        end
    end

    // read-modify-write
    always_comb begin
        cur_cls = (r_fw_cls_valid && (r_fw_cls_addr == r_p2_cls_addr)) ? r_fw_cls_data
                                                                        : r_cls_rd;
        cur_bin = (r_fw_bin_valid && (r_fw_bin_addr == r_p2_bin_addr)) ? r_fw_bin_data
                                                                        : r_bin_rd;
        new_cls.count  = cur_cls.count + 1'b1;
        new_cls.sum    = cur_cls.sum + pis_pkg::ACC_W'(r_p2_cmd.gap);
        new_cls.sum_sq = cur_cls.sum_sq + pis_pkg::ACC_W'(r_p2_sq);
        new_bin        = cur_bin + 1'b1;
    end

    assign upd_cls = en && r_p2_valid && (r_p2_cmd.op == pis_pkg::OP_UPD_CLASS);
    assign upd_bin = en && r_p2_valid && (r_p2_cmd.op == pis_pkg::OP_UPD_BIN);

    always_comb begin
        if (r_clearing) begin
            cls_we = 32'(r_clr_idx) < 32'(pis_pkg::NUM_CLASSES);
            cls_wa = r_clr_idx[pis_pkg::CLS_IDX_W-1:0];
            cls_wd = '0;
            bin_we = 32'(r_clr_idx) <= 32'(pis_pkg::NUM_BINS);
            bin_wa = r_clr_idx[pis_pkg::BIN_IDX_W-1:0];
            bin_wd = '0;
        end else begin
            cls_we = upd_cls;
            cls_wa = r_p2_cls_addr;
            cls_wd = new_cls;
            bin_we = upd_bin;
            bin_wa = r_p2_bin_addr;
            bin_wd = new_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cls_we) begin
            cls_mem[cls_wa] <= cls_wd;
        end
        if (en) begin
            r_cls_rd <= cls_mem[cls_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            bin_mem[bin_wa] <= bin_wd;
        end
        if (en) begin
            r_bin_rd <= bin_mem[bin_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_cls_valid <= 1'b0;
            r_fw_bin_valid <= 1'b0;
        end else if (r_clearing) begin
            r_fw_cls_valid <= 1'b0;
            r_fw_bin_valid <= 1'b0;
        end else begin
            if (upd_cls) begin
                r_fw_cls_valid <= 1'b1;
            end
            if (upd_bin) begin
                r_fw_bin_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_cls) begin
            r_fw_cls_addr <= r_p2_cls_addr;
            r_fw_cls_data <= new_cls;
        end
        if (upd_bin) begin
            r_fw_bin_addr <= r_p2_bin_addr;
            r_fw_bin_data <= new_bin;
        end
    end

    // result
    always_comb begin
        res.matched         = r_p2_cmd.matched;
        res.updated         = 1'b0;
        res.entry_count     = '0;
        res.entry_sum_us    = '0;
        res.entry_sum_sq    = '0;
        res.total_matched   = r_p2_cmd.total_matched;
        res.unmatched_total = r_p2_cmd.unmatched_total;
        unique case (r_p2_cmd.op)
            pis_pkg::OP_RD_CLASS: begin
                res.entry_count  = cur_cls.count;
                res.entry_sum_us = cur_cls.sum;
                res.entry_sum_sq = cur_cls.sum_sq;
            end
            pis_pkg::OP_RD_BIN: begin
                res.entry_count = cur_bin;
            end
            pis_pkg::OP_UPD_CLASS: begin
                res.updated      = 1'b1;
                res.entry_count  = new_cls.count;
                res.entry_sum_us = new_cls.sum;
                res.entry_sum_sq = new_cls.sum_sq;
            end
            pis_pkg::OP_UPD_BIN: begin
                res.updated     = 1'b1;
                res.entry_count = new_bin;
            end
            default: ;
        endcase
    end

    // result queue
    assign oq_push    = en && r_p2_valid;
    assign o_empty    = r_oq_cnt == '0;
    assign oq_pop     = i_pop && !o_empty;
    assign o_out_item = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wp <= (r_oq_wp == OQ_PTR_W'(pis_pkg::OUTQ_DEPTH - 1)) ? '0
                                                                           : r_oq_wp + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rp <= (r_oq_rp == OQ_PTR_W'(pis_pkg::OUTQ_DEPTH - 1)) ? '0
                                                                           : r_oq_rp + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= res;
        end
    end

endmodule

// ===== sv/packet_interarrival_stats.sv =====
// a result reaches the output through the command queue, the p1 and p2 registers and the result queue
// throughput: one item per cycle while the result queue has room and no clearing pass runs, set by the
// 3-stage back pipeline with one memory read and one write each cycle and forwarding between updates
// reset: synchronous, active low; then a clearing pass over every entry of the
// statistics memories holds full high, configuration writes still taken
module packet_interarrival_stats (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  pis_pkg::t_in_item              i_in_item,
    output logic                           empty,
    input  logic                           pop,
    output pis_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic          busy;
    logic          q_full;
    logic          cmd_push;
    pis_pkg::t_cmd cmd;
    logic          head_valid;
    pis_pkg::t_cmd head;
    logic          head_pop;

    pis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_item   (i_in_item),
        .o_full      (full),
        .i_busy      (busy),
        .i_q_full    (q_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pis_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head),
        .i_pop   (head_pop)
    );

    pis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head),
        .o_cmd_pop   (head_pop),
        .o_busy      (busy),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/pis_checker.sv =====
`include "assert_macros.svh"

module pis_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input pis_pkg::t_out_item o_out_item
);

    // reset drops waiting results and starts the clearing pass
    `PIS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty)
    `PIS_ASSERT_ALWAYS(a_reset_full, i_clk, !i_rst_n |=> full)

    // a changed entry only comes from a consumed packet
    `PIS_ASSERT(a_upd_matched, i_clk, i_rst_n, (!empty && o_out_item.updated) |-> o_out_item.matched)

    `PIS_ASSERT(a_out_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_item)))

endmodule

bind packet_interarrival_stats pis_checker u_pis_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
